@@ design/prl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

    localparam int POS_W   = 6;
    localparam int NAME_W  = 64;
    localparam int GRADE_W = 8;
    localparam int MEAN_W  = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MEAN   = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // what a cell loads on the next edge
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_LOAD,
        CM_LEFT,
        CM_RIGHT,
        CM_HEAD
    } t_cell_mode;

endpackage

`default_nettype wire

@@ design/positional_record_list.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered record list held in a chain of DEPTH cells, cell 0 at the front.
// Input channel (i_in_valid / o_in_ready) takes one request: insert after
// i_position, remove at 1-based i_position, mean of grades, or dump.
// Output channel (o_out_valid / i_out_ready) returns the results; o_last
// marks the final result of a request.
// Insert and remove shift the cells in the accept cycle; the result goes
// to S_EMIT and is then registered on the output. Mean rotates the list
// once through cell 0, then runs an 8-step divider.
// Dump rotates the list one record per delivered result, so it gives one
// result per cycle while the receiver takes them, count results in all.
// One request is handled at a time; o_in_ready is high whenever the
// sequencer is idle, also while the last result still waits to be taken.
// A stalled receiver freezes the dump rotation and holds the result.
// Synchronous reset empties the list and drops any pending result; cell
// contents are not cleared, since only entries below the count are read.
module positional_record_list import prl_pkg::*; #(
    parameter int DEPTH      = 32,
    parameter int NAME_BYTES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [NAME_W-1:0]  i_name_tag,
    input  wire logic [GRADE_W-1:0] i_grade_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [1:0]         o_status,
    output logic      [NAME_W-1:0]  o_entry_name,
    output logic      [GRADE_W-1:0] o_entry_grade,
    output logic      [MEAN_W-1:0]  o_mean_grade,
    output logic      [POS_W-1:0]   o_entry_count,
    output logic                    o_last
);

    localparam int NW   = 8 * NAME_BYTES;
    localparam int W    = NW + GRADE_W;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW   = $clog2(DEPTH * 255 + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_EMIT,
        S_DUMP
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_iter;
    logic [SW-1:0]     r_sum;
    logic [1:0]        r_pstat;
    logic [MEAN_W-1:0] r_pmean;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [NAME_W-1:0]  r_name;
    logic [GRADE_W-1:0] r_grade;
    logic [MEAN_W-1:0]  r_mean;
    logic [POS_W-1:0]   r_ocount;
    logic               r_last;

    logic [W-1:0] w_cell [DEPTH];
    t_cell_mode   w_mode [DEPTH];
    logic [W-1:0] w_new;
    logic [W-1:0] w_head;

    logic [CMPW-1:0]   w_pos;
    logic [CMPW-1:0]   w_cnt;
    logic [1:0]        w_ins_stat;
    logic [1:0]        w_rem_stat;
    logic              w_empty;
    logic              w_out_free;
    logic              w_emit;
    logic              w_accept;
    logic              w_do_ins;
    logic              w_do_rem;
    logic              w_do_rot;
    logic              w_iter_last;
    logic [SW-1:0]     w_sum_next;
    logic              w_div_start;
    logic              w_div_done;
    logic [MEAN_W-1:0] w_quot;

    assign w_pos      = CMPW'(i_position);
    assign w_cnt      = CMPW'(r_count);
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = ((r_state == S_EMIT) || (r_state == S_DUMP)) && w_out_free;
    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_new      = {i_name_tag[NW-1:0], i_grade_in};
    assign w_head     = w_cell[0];

    always_comb begin
        if (w_pos > w_cnt) begin
            w_ins_stat = ST_BADPOS;
        end else if (w_cnt >= CMPW'(DEPTH)) begin
            w_ins_stat = ST_FULL;
        end else begin
            w_ins_stat = ST_OK;
        end
        if (w_empty) begin
            w_rem_stat = ST_EMPTY;
        end else if (w_pos == '0 || w_pos > w_cnt) begin
            w_rem_stat = ST_BADPOS;
        end else begin
            w_rem_stat = ST_OK;
        end
    end

    assign w_do_ins    = w_accept && (i_op == OP_INSERT) && (w_ins_stat == ST_OK);
    assign w_do_rem    = w_accept && (i_op == OP_REMOVE) && (w_rem_stat == ST_OK);
    assign w_do_rot    = (r_state == S_SUM) || ((r_state == S_DUMP) && w_out_free);
    assign w_iter_last = ((CMPW'(r_iter) + 1'b1) == w_cnt);
    assign w_sum_next  = r_sum + SW'(w_head[GRADE_W-1:0]);
    assign w_div_start = (r_state == S_SUM) && w_iter_last;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [CMPW-1:0] w_idx;
        logic [CMPW-1:0] w_idx1;
        logic [W-1:0]    w_left;
        logic [W-1:0]    w_right;

        assign w_idx  = CMPW'(g);
        assign w_idx1 = CMPW'(g + 1);

        if (g == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end

        always_comb begin
            w_mode[g] = CM_HOLD;
            if (w_do_ins) begin
                if (w_idx == w_pos) begin
                    w_mode[g] = CM_LOAD;
                end else if (w_idx > w_pos && w_idx <= w_cnt) begin
                    w_mode[g] = CM_LEFT;
                end
            end else if (w_do_rem) begin
                if (w_idx1 >= w_pos && w_idx1 < w_cnt) begin
                    w_mode[g] = CM_RIGHT;
                end
            end else if (w_do_rot) begin
                // front record wraps to the tail of the occupied part
                if (w_idx1 < w_cnt) begin
                    w_mode[g] = CM_RIGHT;
                end else if (w_idx1 == w_cnt) begin
                    w_mode[g] = CM_HEAD;
                end
            end
        end

        prl_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode[g]),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_data  (w_cell[g])
        );
    end

    prl_div #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_sum_next),
        .i_div   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pmean <= '0;
                        r_iter  <= '0;
                        r_sum   <= '0;
                        unique case (i_op)
                            OP_INSERT: begin
                                r_pstat <= w_ins_stat;
                                if (w_ins_stat == ST_OK) begin
                                    r_count <= CW'(r_count + 1'b1);
                                end
                                r_state <= S_EMIT;
                            end
                            OP_REMOVE: begin
                                r_pstat <= w_rem_stat;
                                if (w_rem_stat == ST_OK) begin
                                    r_count <= CW'(r_count - 1'b1);
                                end
                                r_state <= S_EMIT;
                            end
                            OP_MEAN: begin
                                r_pstat <= ST_EMPTY;
                                r_state <= w_empty ? S_EMIT : S_SUM;
                            end
                            OP_DUMP: begin
                                r_pstat <= ST_EMPTY;
                                r_state <= w_empty ? S_EMIT : S_DUMP;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_sum  <= w_sum_next;
                    r_iter <= IW'(r_iter + 1'b1);
                    if (w_iter_last) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pmean <= w_quot;
                        r_pstat <= ST_OK;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_status    <= r_pstat;
                        r_name      <= '0;
                        r_grade     <= '0;
                        r_mean      <= r_pmean;
                        r_ocount    <= POS_W'(r_count);
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        r_status    <= ST_OK;
                        r_name      <= NAME_W'(w_head[W-1:GRADE_W]);
                        r_grade     <= w_head[GRADE_W-1:0];
                        r_mean      <= '0;
                        r_ocount    <= POS_W'(r_count);
                        r_last      <= w_iter_last;
                        r_iter      <= IW'(r_iter + 1'b1);
                        if (w_iter_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_name  = r_name;
    assign o_entry_grade = r_grade;
    assign o_mean_grade  = r_mean;
    assign o_entry_count = r_ocount;
    assign o_last        = r_last;

endmodule

`default_nettype wire

@@ design/prl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prl_cell import prl_pkg::*; #(
    parameter int W = 72
) (
    input  wire logic         i_clk,
    input  wire t_cell_mode   i_mode,
    input  wire logic [W-1:0] i_new,
    input  wire logic [W-1:0] i_left,
    input  wire logic [W-1:0] i_right,
    input  wire logic [W-1:0] i_head,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        case (i_mode)
            CM_LOAD:  r_data <= i_new;
            CM_LEFT:  r_data <= i_left;
            CM_RIGHT: r_data <= i_right;
            CM_HEAD:  r_data <= i_head;
            default:  r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ design/prl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divide, one quotient bit per cycle; quotient known to fit 8 bits
module prl_div import prl_pkg::*; #(
    parameter int SW = 14,
    parameter int CW = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SW-1:0]     i_sum,
    input  wire logic [CW-1:0]     i_div,
    output logic                   o_done,
    output logic      [MEAN_W-1:0] o_quot
);

    localparam int VW = CW + MEAN_W - 1;
    localparam int DW = (SW > VW) ? SW : VW;

    logic [SW-1:0]     r_rem;
    logic [VW-1:0]     r_dvs;
    logic [2:0]        r_k;
    logic              r_busy;
    logic              r_done;
    logic [MEAN_W-1:0] r_quot;

    logic [DW-1:0] w_rem;
    logic [DW-1:0] w_dvs;
    logic [DW-1:0] w_diff;
    logic          w_ge;

    assign w_rem  = DW'(r_rem);
    assign w_dvs  = DW'(r_dvs);
    assign w_ge   = (w_rem >= w_dvs);
    assign w_diff = w_rem - w_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_k == 3'd0);
            if (i_start) begin
                r_rem  <= i_sum;
                r_dvs  <= {i_div, {(MEAN_W-1){1'b0}}};
                r_k    <= 3'd7;
                r_quot <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= SW'(w_diff);
                end
                r_quot <= {r_quot[MEAN_W-2:0], w_ge};
                r_dvs  <= r_dvs >> 1;
                r_k    <= r_k - 3'd1;
                if (r_k == 3'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ design/prl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prl_checker import prl_pkg::*; #(
    parameter int DEPTH = 32
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         o_status,
    input wire logic [NAME_W-1:0]  o_entry_name,
    input wire logic [GRADE_W-1:0] o_entry_grade,
    input wire logic [MEAN_W-1:0]  o_mean_grade,
    input wire logic [POS_W-1:0]   o_entry_count,
    input wire logic               o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_name) && $stable(o_entry_grade)
            && $stable(o_mean_grade) && $stable(o_entry_count) && $stable(o_last))
        else $error("result changed while stalled");

    // an error status always ends the request and carries no record
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_last && o_entry_name == '0 && o_entry_grade == '0 && o_mean_grade == '0)
        else $error("error result with payload or not last");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == POS_W'(DEPTH))
        else $error("full status with count below depth");

    a_mean_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mean_grade != '0 |-> o_last && o_entry_name == '0)
        else $error("mean result mixed with a record");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind positional_record_list prl_checker #(.DEPTH(DEPTH)) u_prl_checker (.*);

`default_nettype wire

@@ tb/positional_record_list_tb.sv @@
`timescale 1ns / 1ps

module positional_record_list_tb import prl_pkg::*;;

    localparam int DEPTH        = 32;
    localparam int NAME_BYTES   = 8;
    localparam int RAND_REQS    = 288;
    localparam int PHASE_LEN    = 48;
    localparam int CALM_REQS    = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [1:0]         status;
        logic [NAME_W-1:0]  name;
        logic [GRADE_W-1:0] grade;
        logic [MEAN_W-1:0]  mean;
        logic [POS_W-1:0]   count;
        logic               last;
    } t_result;

    typedef struct {
        logic [1:0]         op;
        logic [POS_W-1:0]   pos;
        logic [NAME_W-1:0]  name;
        logic [GRADE_W-1:0] grade;
        bit                 pinned;   // expected result written into the row
        t_result            res;
    } t_request;

    typedef enum int {
        PH_GROW,
        PH_CHURN,
        PH_SHRINK
    } t_phase;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic [POS_W-1:0]   i_position;
    logic [NAME_W-1:0]  i_name_tag;
    logic [GRADE_W-1:0] i_grade_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic [NAME_W-1:0]  o_entry_name;
    logic [GRADE_W-1:0] o_entry_grade;
    logic [MEAN_W-1:0]  o_mean_grade;
    logic [POS_W-1:0]   o_entry_count;
    logic               o_last;

    positional_record_list #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_name_tag    (i_name_tag),
        .i_grade_in    (i_grade_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_name  (o_entry_name),
        .o_entry_grade (o_entry_grade),
        .o_mean_grade  (o_mean_grade),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    // shadow copy of the list
    logic [NAME_W-1:0]  roster_name  [DEPTH];
    logic [GRADE_W-1:0] roster_grade [DEPTH];
    int                 roster_len;
    t_result            due_results [$];

    t_request script [$];
    t_request cur_req;
    bit       calm;
    bit       quiet;
    int       stall_left;
    int       errors;
    int       idle_cycles;
    int       results_seen;
    int       op_tally [4];
    int       full_rejects;
    int       max_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result status_result(logic [1:0] st, int cnt, int mean);
        t_result res;
        res        = '0;
        res.status = st;
        res.count  = cnt[POS_W-1:0];
        res.mean   = mean[MEAN_W-1:0];
        res.last   = 1'b1;
        return res;
    endfunction

    task automatic add_step(input logic [1:0] op, input int pos, input logic [NAME_W-1:0] name,
                            input int grade, input int pinned, input logic [1:0] st,
                            input int cnt, input int mean);
        t_request r;
        r.op     = op;
        r.pos    = pos[POS_W-1:0];
        r.name   = name;
        r.grade  = grade[GRADE_W-1:0];
        r.pinned = (pinned != 0);
        r.res    = status_result(st, cnt, mean);
        script.push_back(r);
    endtask

    task automatic apply_request(input t_request r);
        logic [NAME_W-1:0] tag;
        int                sum;
        t_result           res;
        tag = r.name & ({NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES));
        case (r.op)
            OP_INSERT: begin
                if (r.pos > roster_len) begin
                    due_results.push_back(status_result(ST_BADPOS, roster_len, 0));
                end else if (roster_len >= DEPTH) begin
                    full_rejects++;
                    due_results.push_back(status_result(ST_FULL, roster_len, 0));
                end else begin
                    for (int i = roster_len; i > r.pos; i--) begin
                        roster_name[i]  = roster_name[i-1];
                        roster_grade[i] = roster_grade[i-1];
                    end
                    roster_name[r.pos]  = tag;
                    roster_grade[r.pos] = r.grade;
                    roster_len++;
                    if (roster_len > max_len) max_len = roster_len;
                    due_results.push_back(status_result(ST_OK, roster_len, 0));
                end
            end
            OP_REMOVE: begin
                if (roster_len == 0) begin
                    due_results.push_back(status_result(ST_EMPTY, 0, 0));
                end else if (r.pos < 1 || r.pos > roster_len) begin
                    due_results.push_back(status_result(ST_BADPOS, roster_len, 0));
                end else begin
                    for (int i = r.pos - 1; i + 1 < roster_len; i++) begin
                        roster_name[i]  = roster_name[i+1];
                        roster_grade[i] = roster_grade[i+1];
                    end
                    roster_len--;
                    due_results.push_back(status_result(ST_OK, roster_len, 0));
                end
            end
            OP_MEAN: begin
                if (roster_len == 0) begin
                    due_results.push_back(status_result(ST_EMPTY, 0, 0));
                end else begin
                    sum = 0;
                    for (int i = 0; i < roster_len; i++) sum += roster_grade[i];
                    due_results.push_back(status_result(ST_OK, roster_len, sum / roster_len));
                end
            end
            default: begin
                if (roster_len == 0) begin
                    due_results.push_back(status_result(ST_EMPTY, 0, 0));
                end else begin
                    for (int i = 0; i < roster_len; i++) begin
                        res        = '0;
                        res.status = ST_OK;
                        res.name   = roster_name[i];
                        res.grade  = roster_grade[i];
                        res.count  = roster_len[POS_W-1:0];
                        res.last   = (i == roster_len - 1);
                        due_results.push_back(res);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // both channels sampled before the edge updates anything
    always @(posedge i_clk) begin : monitor
        t_result  got;
        t_result  want;
        t_request seen;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                results_seen++;
                got = {o_status, o_entry_name, o_entry_grade, o_mean_grade, o_entry_count,
                       o_last};
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("entry_name", want.name, got.name);
                    check_field("entry_grade", 64'(want.grade), 64'(got.grade));
                    check_field("mean_grade", 64'(want.mean), 64'(got.mean));
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                    check_field("last", 64'(want.last), 64'(got.last));
                end
            end
            // results are checked first so a new request never claims an older result
            if (i_in_valid && o_in_ready) begin
                moved       = 1'b1;
                seen.op     = i_op;
                seen.pos    = i_position;
                seen.name   = i_name_tag;
                seen.grade  = i_grade_in;
                seen.pinned = cur_req.pinned;
                seen.res    = cur_req.res;
                op_tally[i_op]++;
                apply_request(seen);
                if (seen.pinned) begin
                    void'(due_results.pop_back());
                    due_results.push_back(seen.res);
                end
            end
            if (moved) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("positional_record_list_tb failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_request(input t_request r);
        @(negedge i_clk);
        if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        cur_req     = r;
        i_in_valid <= 1'b1;
        i_op       <= r.op;
        i_position <= r.pos;
        i_name_tag <= r.name;
        i_grade_in <= r.grade;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic make_request(input t_phase ph, output t_request r);
        int pick;
        int ins_cut;
        int rem_cut;
        int mean_cut;
        pick = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   begin ins_cut = 80; rem_cut = 85; mean_cut = 92; end
            PH_SHRINK: begin ins_cut = 10; rem_cut = 80; mean_cut = 90; end
            default:   begin ins_cut = 40; rem_cut = 75; mean_cut = 87; end
        endcase
        if (pick < ins_cut)       r.op = OP_INSERT;
        else if (pick < rem_cut)  r.op = OP_REMOVE;
        else if (pick < mean_cut) r.op = OP_MEAN;
        else                      r.op = OP_DUMP;

        // mostly legal positions, the rest anywhere from 0 to DEPTH
        r.pos = POS_W'($urandom_range(0, DEPTH));
        if ($urandom_range(0, 99) < 85) begin
            if (r.op == OP_INSERT)
                r.pos = POS_W'($urandom_range(0, roster_len));
            else if (r.op == OP_REMOVE && roster_len > 0)
                r.pos = POS_W'($urandom_range(1, roster_len));
        end

        case ($urandom_range(0, 9))
            0:       r.name = '0;
            1:       r.name = '1;
            default: r.name = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0:       r.grade = '0;
            1:       r.grade = '1;
            default: r.grade = GRADE_W'($urandom_range(0, 255));
        endcase
        r.pinned = 1'b0;
        r.res    = '0;
    endtask

    initial begin : stimulus
        t_request r;
        t_phase   ph;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_INSERT;
        i_position  = '0;
        i_name_tag  = '0;
        i_grade_in  = '0;
        i_out_ready = 1'b0;
        calm        = 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        errors      = 0;
        idle_cycles = 0;
        roster_len  = 0;
        ph          = PH_GROW;
        cur_req     = '{default: '0};

        // op, position, name, grade, pinned, status, count, mean
        add_step(OP_MEAN,   0,  '0, 0, 1, ST_EMPTY, 0, 0);
        add_step(OP_DUMP,   0,  '0, 0, 1, ST_EMPTY, 0, 0);
        add_step(OP_REMOVE, 32, '0, 0, 1, ST_EMPTY, 0, 0);   // position ignored when empty
        add_step(OP_INSERT, 1,  64'h00000000deadbeef, 'h11, 1, ST_BADPOS, 0, 0);
        add_step(OP_INSERT, 32, 64'h00000000deadbeef, 'h11, 1, ST_BADPOS, 0, 0);
        add_step(OP_INSERT, 0,  '1, 255, 1, ST_OK, 1, 0);
        add_step(OP_MEAN,   0,  '0, 0, 1, ST_OK, 1, 255);
        add_step(OP_INSERT, 0,  '0, 0, 1, ST_OK, 2, 0);
        add_step(OP_MEAN,   0,  '0, 0, 1, ST_OK, 2, 127);
        add_step(OP_INSERT, 2,  64'h0123456789abcdef, 128, 0, ST_OK, 0, 0);
        add_step(OP_INSERT, 1,  64'h8000000000000001, 1, 0, ST_OK, 0, 0);
        add_step(OP_DUMP,   0,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_REMOVE, 0,  '0, 0, 1, ST_BADPOS, 4, 0);
        add_step(OP_REMOVE, 5,  '0, 0, 1, ST_BADPOS, 4, 0);
        add_step(OP_INSERT, 5,  '1, 7, 1, ST_BADPOS, 4, 0);
        add_step(OP_MEAN,   0,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_REMOVE, 4,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_REMOVE, 1,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_DUMP,   0,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_REMOVE, 1,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_REMOVE, 1,  '0, 0, 0, ST_OK, 0, 0);
        add_step(OP_DUMP,   0,  '0, 0, 1, ST_EMPTY, 0, 0);
        add_step(OP_MEAN,   0,  '0, 0, 1, ST_EMPTY, 0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) send_request(script[k]);

        for (int n = 0; n < RAND_REQS; n++) begin
            if (n % PHASE_LEN == 0) begin
                ph    = t_phase'((n / PHASE_LEN) % 3);
                quiet = ($urandom_range(0, 3) == 0);
            end
            calm = (n >= RAND_REQS - CALM_REQS);
            make_request(ph, r);
            send_request(r);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
            errors += due_results.size();
        end

        $display("requests: %0d insert, %0d remove, %0d mean, %0d dump; %0d results checked",
                 op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_MEAN],
                 op_tally[OP_DUMP], results_seen);
        $display("list peaked at %0d records, %0d inserts refused as full, %0d errors",
                 max_len, full_rejects, errors);
        if (errors == 0) begin
            $display("positional_record_list_tb passed");
        end else begin
            $display("positional_record_list_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/prl_pkg.sv
design/prl_cell.sv
design/prl_div.sv
design/positional_record_list.sv
design/prl_checker.sv
tb/positional_record_list_tb.sv
